/* hw/rtl/ils_pkg.sv */
`default_nettype none

package ils_pkg;

	localparam int CAPACITY = 256;

	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 9;
	localparam int VALUE_W  = 64;
	localparam int COUNT_W  = 9;

	// internal widths follow the capacity
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int POS_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	// read-out OR tree: groups of cells reduced and registered, then the groups
	localparam int GRP  = 16;
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	typedef enum logic [ACTION_W-1:0] {
		ACT_GET        = 3'd0,
		ACT_SET        = 3'd1,
		ACT_INSERT     = 3'd2,
		ACT_EXTRACT    = 3'd3,
		ACT_PUSH_BACK  = 3'd4,
		ACT_PUSH_FRONT = 3'd5,
		ACT_POP_BACK   = 3'd6,
		ACT_POP_FRONT  = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_INSERT,
		OP_EXTRACT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  pos;
		logic [VALUE_W-1:0] value;
		logic              rd;
	} cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/indexed_list_store.sv */
// Channel  Dir  tdata fields (low bit up)                          Width
// s_axis   in   action[2:0] index[11:3] value[75:12], zero pad    80
// m_axis   out  status[0] read_value[64:1] count_after[73:65], pad 80
//
// Every transaction is applied to the cell row as a whole: all cells shift or load
// together at the accepting edge, so a new request is taken every cycle unless
// the output stalls. Results are registered after the OR tree and at the output.
// Reset clears the count and the pipeline valids; cell contents stay undefined.
// A stalled master side holds the result and back-pressures the slave side.
`default_nettype none

module indexed_list_store
	import ils_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // action, index, value
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata   // status, read_value, count_after
);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	cmd_t               cmd;
	logic               ok;
	logic               accept;
	logic               adv_out;

	logic [VALUE_W-1:0] cell_data [CAPACITY];
	logic [VALUE_W-1:0] cell_rd   [CAPACITY];

	logic [VALUE_W-1:0] grp_or    [NGRP];
	logic [VALUE_W-1:0] grp_s1    [NGRP];
	logic               valid_s1;
	logic               status_s1;
	logic [CNT_W-1:0]   count_s1;
	logic [VALUE_W-1:0] rd_all;

	logic               out_valid_q;
	logic               status_q;
	logic [VALUE_W-1:0] read_value_q;
	logic [COUNT_W-1:0] count_after_q;

	assign adv_out       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_out;
	assign accept        = s_axis_tvalid && s_axis_tready;

	ils_ctrl u_ctrl (
		.action    (s_axis_tdata[2:0]),
		.index     (s_axis_tdata[11:3]),
		.value     (s_axis_tdata[75:12]),
		.count     (count_q),
		.cmd       (cmd),
		.ok        (ok),
		.count_nxt (count_nxt)
	);

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [VALUE_W-1:0] left_d;
		logic [VALUE_W-1:0] right_d;

		if (k == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[k+1];
		end

		ils_cell u_cell (
			.clk     (clk),
			.en      (accept),
			.idx     (IDX_W'(k)),
			.cmd     (cmd),
			.left    (left_d),
			.right   (right_d),
			.data    (cell_data[k]),
			.rd_data (cell_rd[k])
		);
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_or[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < CAPACITY)
					grp_or[g] = grp_or[g] | cell_rd[g*GRP+j];
			end
		end

		always_ff @(posedge clk) begin
			if (accept)
				grp_s1[g] <= grp_or[g];
		end
	end

	always_comb begin
		rd_all = '0;
		for (int g = 0; g < NGRP; g++)
			rd_all = rd_all | grp_s1[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				count_q <= count_nxt;
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_out)
				valid_s1 <= 1'b0;
			if (adv_out)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= !ok;
			count_s1  <= count_nxt;
		end
		if (adv_out) begin
			status_q      <= status_s1;
			read_value_q  <= rd_all;
			count_after_q <= COUNT_W'(count_s1);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, count_after_q, read_value_q, status_q};

endmodule

`default_nettype wire

/* hw/rtl/ils_ctrl.sv */
`default_nettype none

module ils_ctrl
	import ils_pkg::*;
(
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [INDEX_W-1:0]  index,
	input  wire logic [VALUE_W-1:0]  value,
	input  wire logic [CNT_W-1:0]    count,
	output cmd_t                     cmd,
	output logic                     ok,
	output logic [CNT_W-1:0]         count_nxt
);

	logic [POS_W-1:0] cnt_ext;
	logic [POS_W-1:0] idx_ext;
	logic             full;
	logic             empty;
	logic             in_range;
	act_t             act;

	assign cnt_ext  = POS_W'(count);
	assign idx_ext  = POS_W'(index);
	assign full     = (count == CNT_W'(CAPACITY));
	assign empty    = (count == '0);
	assign in_range = (idx_ext < cnt_ext);
	assign act      = act_t'(action);

	always_comb begin
		ok        = 1'b0;
		cmd.op    = OP_NONE;
		cmd.pos   = idx_ext;
		cmd.value = value;
		cmd.rd    = 1'b0;
		count_nxt = count;
		unique case (act)
			ACT_GET: begin
				ok     = in_range;
				cmd.rd = in_range;
			end
			ACT_SET: begin
				ok = in_range;
				if (in_range)
					cmd.op = OP_WRITE;
			end
			ACT_INSERT, ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
				if (act == ACT_PUSH_BACK)
					cmd.pos = cnt_ext;
				else if (act == ACT_PUSH_FRONT)
					cmd.pos = '0;
				ok = !full && (act != ACT_INSERT || idx_ext <= cnt_ext);
				if (ok) begin
					cmd.op    = OP_INSERT;
					count_nxt = count + CNT_W'(1);
				end
			end
			ACT_EXTRACT, ACT_POP_BACK, ACT_POP_FRONT: begin
				if (act == ACT_POP_BACK)
					cmd.pos = cnt_ext - POS_W'(1);
				else if (act == ACT_POP_FRONT)
					cmd.pos = '0;
				ok = (act == ACT_EXTRACT) ? in_range : !empty;
				if (ok) begin
					cmd.op    = OP_EXTRACT;
					cmd.rd    = 1'b1;
					count_nxt = count - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/ils_cell.sv */
`default_nettype none

module ils_cell
	import ils_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [IDX_W-1:0]   idx,
	input  cmd_t                    cmd,
	input  wire logic [VALUE_W-1:0] left,
	input  wire logic [VALUE_W-1:0] right,
	output logic [VALUE_W-1:0]      data,
	output logic [VALUE_W-1:0]      rd_data
);

	logic [VALUE_W-1:0] data_q;
	logic [VALUE_W-1:0] data_nxt;
	logic [POS_W-1:0]   me;
	logic               hit;
	logic               above;

	assign me    = POS_W'(idx);
	assign hit   = (me == cmd.pos);
	assign above = (me > cmd.pos);

	always_comb begin
		data_nxt = data_q;
		unique case (cmd.op)
			OP_WRITE: begin
				if (hit)
					data_nxt = cmd.value;
			end
			OP_INSERT: begin
				if (above)
					data_nxt = left;
				else if (hit)
					data_nxt = cmd.value;
			end
			OP_EXTRACT: begin
				if (above || hit)
					data_nxt = right;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= data_nxt;
	end

	assign data    = data_q;
	// old contents, seen by the read tree in the same cycle as the shift
	assign rd_data = (cmd.rd && hit) ? data_q : '0;

endmodule

`default_nettype wire
